// ===== rtl/core/lct_pkg.sv =====
// Shared types for the label count table: request and response payloads,
// and the command and status groups between controller and datapath.
// No dependencies.
`default_nettype none

package lct_pkg;

   localparam int unsigned LabelWidth = 32;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned UsedWidth  = 5;

   // Request kinds
   localparam logic KindUpdate = 1'b0;
   localparam logic KindQuery  = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [LabelWidth-1:0]  label;
      logic signed [CountWidth-1:0]  count_delta;
   } lct_req_type;

   typedef struct packed {
      logic signed [CountWidth-1:0]  label_count;
      logic                          label_found;
      logic                          table_full;
      logic [UsedWidth-1:0]          entries_used;
   } lct_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch request, compare labels
      logic lookup;    // encode match, read count
      logic commit;    // write table, load response
   } lct_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_busy;  // response register holds an unaccepted response
   } lct_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/lct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lct_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lct_ctrl.sv =====
// Sequencer for the label count table: capture, lookup, commit.
// Depends on lct_pkg.
`default_nettype none

module lct_ctrl
   import lct_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire lct_status_type status,
   output lct_cmd_type         cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the response register is free
            if (!status.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lct_dp.sv =====
// Datapath of the label count table: label registers with per-entry
// comparators, valid bits, count RAM, saturating adder, response register.
// Depends on lct_pkg and lct_ram.
`default_nettype none

module lct_dp
   import lct_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire lct_req_type    req_data,
   input  wire lct_cmd_type    cmd,
   output lct_status_type      status,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output lct_rsp_type         rsp_data
);

   localparam int unsigned IdxWidth = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CntWidth = $clog2(ENTRIES + 1);

   // lowest set bit wins
   function automatic logic [IdxWidth-1:0] first_set(input logic [ENTRIES-1:0] vec);
      logic [IdxWidth-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IdxWidth'(i);
         end
      end
      return idx;
   endfunction

   // Request
   logic                   kind_ff;
   logic [LabelWidth-1:0]  label_ff;
   logic [CountWidth-1:0]  delta_ff;

   // Table
   logic [LabelWidth-1:0]  label_store_ff [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff;
   logic [CntWidth-1:0]    used_ff;
   logic [CntWidth-1:0]    used_in;

   // Search results
   logic [ENTRIES-1:0]     hit_vec_ff;
   logic [ENTRIES-1:0]     free_vec_ff;
   logic [IdxWidth-1:0]    hit_idx_ff;
   logic [IdxWidth-1:0]    free_idx_ff;
   logic                   found_ff;
   logic                   have_free_ff;
   logic [IdxWidth-1:0]    hit_idx_in;

   // Count RAM
   logic                   ram_wr_en;
   logic [IdxWidth-1:0]    ram_wr_addr;
   logic [CountWidth-1:0]  ram_wr_data;
   logic [CountWidth-1:0]  ram_rd_data;

   // Commit logic
   logic [CountWidth:0]    sum_wide;
   logic [CountWidth-1:0]  sum_sat;
   logic                   is_update;
   logic                   alloc;
   logic                   full;
   logic [CountWidth-1:0]  result_count;
   logic [CntWidth+UsedWidth-1:0] used_ext;

   // Response
   logic                   rsp_valid_ff;
   lct_rsp_type            rsp_data_ff;

   assign hit_idx_in = first_set(hit_vec_ff);

   lct_ram #(
      .WIDTH (CountWidth),
      .DEPTH (ENTRIES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (hit_idx_in),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      sum_wide = {ram_rd_data[CountWidth-1], ram_rd_data}
               + {delta_ff[CountWidth-1], delta_ff};
      if (sum_wide[CountWidth] != sum_wide[CountWidth-1]) begin
         // clamp toward the sign of the true sum
         sum_sat = {sum_wide[CountWidth], {(CountWidth-1){~sum_wide[CountWidth]}}};
      end else begin
         sum_sat = sum_wide[CountWidth-1:0];
      end

      is_update = (kind_ff == KindUpdate);
      alloc     = is_update && !found_ff && have_free_ff;
      full      = is_update && !found_ff && !have_free_ff;

      ram_wr_en   = cmd.commit && is_update && (found_ff || have_free_ff);
      ram_wr_addr = found_ff ? hit_idx_ff : free_idx_ff;
      ram_wr_data = found_ff ? sum_sat : delta_ff;

      if (found_ff) begin
         result_count = is_update ? sum_sat : ram_rd_data;
      end else if (alloc) begin
         result_count = delta_ff;
      end else begin
         result_count = '0;
      end

      used_in  = alloc ? used_ff + CntWidth'(1) : used_ff;
      used_ext = {{UsedWidth{1'b0}}, used_in};
   end

   // Request capture and per-entry compare
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_data.req_type;
         label_ff <= req_data.label;
         delta_ff <= req_data.count_delta;
         for (int i = 0; i < ENTRIES; i++) begin
            hit_vec_ff[i] <= valid_ff[i] && (label_store_ff[i] == req_data.label);
         end
         free_vec_ff <= ~valid_ff;
      end
      if (cmd.lookup) begin
         hit_idx_ff   <= hit_idx_in;
         found_ff     <= |hit_vec_ff;
         free_idx_ff  <= first_set(free_vec_ff);
         have_free_ff <= |free_vec_ff;
      end
      if (cmd.commit && alloc) begin
         label_store_ff[free_idx_ff] <= label_ff;
      end
      if (cmd.commit) begin
         rsp_data_ff.label_count  <= result_count;
         rsp_data_ff.label_found  <= found_ff;
         rsp_data_ff.table_full   <= full;
         rsp_data_ff.entries_used <= used_ext[UsedWidth-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            used_ff <= used_in;
            if (alloc) begin
               valid_ff[free_idx_ff] <= 1'b1;
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/label_count_table.sv =====
// Top level of the label count table: associative (label, count) store.
// Depends on lct_pkg, lct_ctrl, lct_dp (and lct_ram through lct_dp).
//
// Each request passes through capture, lookup and commit in turn. In the
// cycle in which it is accepted, every stored label is compared against the
// request label in parallel. In the next, the lowest matching entry and the
// lowest free entry are encoded and the count RAM is read. At commit, the
// saturated sum is written back and the response register is loaded. The
// next request is accepted in the cycle after commit; compare, lookup and
// commit run one after another, with no overlap between requests. A finished
// response waits in its own register, so a new request is taken while it is
// still unclaimed; a request only holds at commit when the previous response
// is still waiting. An update that hits adds its delta with saturation at
// the 32-bit signed limits; one that misses claims the lowest free entry
// with the delta as its count, or is dropped with table_full set when no
// entry is free. A query never changes the table and reports zero for an
// absent label. entries_used carries the low five bits of the number of
// entries in use after the request. Reset clears the valid bits and the use
// count at once; no clearing pass is needed.
`default_nettype none

module label_count_table
   import lct_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire lct_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output lct_rsp_type      rsp_data
);

   lct_cmd_type    cmd;
   lct_status_type status;

   // Sequence each request through capture, lookup and commit.
   lct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the table, run the compare and the saturating update.
   lct_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
